>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes of the sorted-array priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int FILL_W       = 5;

    localparam logic       KIND_ENQ     = 1'b0;
    localparam logic       KIND_DEQ     = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // one stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // request beat
    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } req_beat_t;

    // response beat
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] out_value;
        logic signed [DATA_W-1:0] out_priority;
        logic [FILL_W-1:0]        fill_level;
    } rsp_beat_t;

    // command broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } cmd_t;

endpackage

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compares, shifts down on insert, up on remove
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic            clk,
    input  spq_pkg::cmd_t   cmd,
    input  logic            occupied,
    input  logic            at_tail,
    input  spq_pkg::entry_t left_entry,
    input  logic            left_lower,
    input  spq_pkg::entry_t right_entry,
    output spq_pkg::entry_t entry,
    output logic            lower
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // held entry ranks strictly below the incoming one
    assign lower = occupied && (entry_reg.prio < cmd.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.enq)
        begin
            if (left_lower)
            begin
                entry_next = left_entry;
            end
            else if (lower || at_tail)
            begin
                entry_next = cmd.item;
            end
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> hw/rtl/sorted_array_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_top
// bounded priority queue held in a chain of cells sorted by priority
// ----------------------------------------------------------------------------
//  channel  signals                      beat type    accepted when
//  req      req_valid req_ready req      req_beat_t   req_valid && req_ready
//  rsp      rsp_valid rsp_ready rsp      rsp_beat_t   rsp_valid && rsp_ready
//
//  on each accepted request all cells compare against the new priority
//  in parallel and shift on the same edge
//  one response beat per request, held in an output register; a new request
//  is taken while the held beat is being taken in the same cycle
//  reset clears the entry count and the response valid, cell contents are
//  don't-care until used
//  a stalled response blocks further requests, nothing is dropped
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  spq_pkg::req_beat_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output spq_pkg::rsp_beat_t  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // entry count and output register
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                rsp_valid_reg;
    spq_pkg::rsp_beat_t  rsp_reg;
    spq_pkg::rsp_beat_t  rsp_next;

    logic                req_fire;
    logic                is_full;
    logic                is_empty;
    spq_pkg::cmd_t       cmd;

    // chain wiring
    spq_pkg::entry_t     cell_entry [CAPACITY];
    logic                cell_lower [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    // broadcast command, only for requests that change the store
    assign cmd.enq        = req_fire && (req.kind == spq_pkg::KIND_ENQ) && !is_full;
    assign cmd.deq        = req_fire && (req.kind == spq_pkg::KIND_DEQ) && !is_empty;
    assign cmd.item.value = req.item_value;
    assign cmd.item.prio  = req.item_priority;

    // cell i is occupied below the count; the cell at the count takes a tail insert
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::entry_t left_entry;
        logic            left_lower;
        spq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = cmd.item;
            assign left_lower = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_lower = cell_lower[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (CNT_W'(i) < count_reg),
            .at_tail     (CNT_W'(i) == count_reg),
            .left_entry  (left_entry),
            .left_lower  (left_lower),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .lower       (cell_lower[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // response beat for the accepted request
    always_comb
    begin
        rsp_next.status       = spq_pkg::STATUS_OK;
        rsp_next.out_value    = '0;
        rsp_next.out_priority = '0;
        rsp_next.fill_level   = spq_pkg::FILL_W'(count_next);
        if (req.kind == spq_pkg::KIND_ENQ)
        begin
            if (is_full)
            begin
                rsp_next.status = spq_pkg::STATUS_FULL;
            end
        end
        else
        begin
            if (is_empty)
            begin
                rsp_next.status = spq_pkg::STATUS_EMPTY;
            end
            else
            begin
                rsp_next.out_value    = cell_entry[0].value;
                rsp_next.out_priority = cell_entry[0].prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // count stays within the chain
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // head of the chain ranks at least as high as its neighbour
    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("chain head out of order");

    // enqueue on a full queue is refused and leaves the count alone
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.kind == spq_pkg::KIND_ENQ) && is_full)
        |=> (rsp.status == spq_pkg::STATUS_FULL) && (count_reg == CNT_W'(CAPACITY)))
        else $error("enqueue on full queue not refused");

    // dequeue on an empty queue reports empty with zero value
    a_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.kind == spq_pkg::KIND_DEQ) && is_empty)
        |=> (rsp.status == spq_pkg::STATUS_EMPTY) && (rsp.out_value == '0)
            && (count_reg == '0))
        else $error("dequeue on empty queue not reported");

endmodule
